/* src/sfd_pkg.sv */
`default_nettype none

package sfd_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [7:0] SYNC_A     = 8'h55;
    localparam logic [7:0] SYNC_B     = 8'h33;
    localparam logic [7:0] STUFF_BYTE = 8'haa;
    localparam logic [7:0] LEN_PAD    = 8'h00;

    localparam logic [15:0] MAX_LEN_RESET = 16'd70;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_LEN_LO   = 3'd2,
        PH_LEN_FILL = 3'd3,
        PH_LEN_HI   = 3'd4,
        PH_BODY     = 3'd5,
        PH_CHECK    = 3'd6,
        PH_STUFF    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_ACCEPT   = 2'd1,
        KIND_CSUM_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase      phase;
        t_phase      resume;
        logic        last_sync;
        logic [15:0] frame_len;
        logic [15:0] counted;
        logic [15:0] payload;
        logic [7:0]  sum;
        logic [15:0] errors;
    } t_chan_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic        first;
        logic [15:0] payload_length;
        logic [15:0] error_total;
    } t_result;

endpackage

`default_nettype wire

/* src/sfd_if.sv */
`default_nettype none

interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [7:0] rx_byte;
    logic       slot_free;

    modport source (output valid, channel, rx_byte, slot_free, input ready);
    modport sink   (input valid, channel, rx_byte, slot_free, output ready);
endinterface

interface sfd_out_if;
    logic          valid;
    logic          ready;
    logic          out_channel;
    sfd_pkg::t_kind kind;
    logic [7:0]    byte_value;
    logic          first_of_message;
    logic [15:0]   payload_length;
    logic [15:0]   error_total;

    modport source (output valid, out_channel, kind, byte_value, first_of_message,
                    payload_length, error_total, input ready);
    modport sink   (input valid, out_channel, kind, byte_value, first_of_message,
                    payload_length, error_total, output ready);
endinterface

`default_nettype wire

/* src/sync_stuffed_frame_decoder.sv */
`default_nettype none

// Channel   Dir  Handshake      Contents
// i_in      in   valid/ready    channel, rx_byte, slot_free
// o_out     out  valid/ready    out_channel, kind, byte_value, first_of_message,
//                               payload_length, error_total
// i_cfg     in   write enable   max_frame_length
//
// One word is accepted per cycle while the output is not stalled. Each word
// reads its channel's state from the state memory into a register; the decode
// stage then decodes it, and when it advances the state is written back and the
// result is loaded into the output register at the same edge.
// The per-entry valid bits make every channel read as its reset state at once
// after reset. A stalled output holds the decode stage and then input.

module sync_stuffed_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfd_in_if.sink           i_in,
    sfd_out_if.source        o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    logic [15:0] r_max_len;

    logic                        r_s1_valid;
    logic [sfd_pkg::CH_AW-1:0]   r_s1_addr;
    logic                        r_s1_ch;
    logic [7:0]                  r_s1_byte;

    logic                        r_out_valid;
    logic                        r_out_ch;
    sfd_pkg::t_result            r_out;

    logic                        s1_adv;
    logic                        take;
    logic                        in_range;
    sfd_pkg::t_chan_state        cur_state;
    sfd_pkg::t_chan_state        next_state;
    logic                        res_valid;
    sfd_pkg::t_result            res;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = s1_adv || !r_s1_valid;
    assign in_range   = ({31'd0, i_in.channel} < sfd_pkg::NUM_CHANNELS);
    // Words without a free slot are consumed and leave no trace.
    assign take       = i_in.valid && i_in.ready && i_in.slot_free && in_range;

    sfd_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (take),
        .i_rd_addr (sfd_pkg::CH_AW'(i_in.channel)),
        .o_rd_data (cur_state),
        .i_wr_en   (r_s1_valid && s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (next_state)
    );

    sfd_decode u_dec (
        .i_cur       (cur_state),
        .i_byte      (r_s1_byte),
        .i_max_len   (r_max_len),
        .o_next      (next_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= sfd_pkg::MAX_LEN_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_addr <= sfd_pkg::CH_AW'(i_in.channel);
            r_s1_ch   <= i_in.channel;
            r_s1_byte <= i_in.rx_byte;
        end
        if (s1_adv) begin
            r_out_ch <= r_s1_ch;
            r_out    <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.out_channel      = r_out_ch;
    assign o_out.kind             = r_out.kind;
    assign o_out.byte_value       = r_out.byte_value;
    assign o_out.first_of_message = r_out.first;
    assign o_out.payload_length   = r_out.payload_length;
    assign o_out.error_total      = r_out.error_total;

endmodule

`default_nettype wire

/* src/sfd_state_mem.sv */
`default_nettype none

module sfd_state_mem (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [sfd_pkg::CH_AW-1:0] i_rd_addr,
    output sfd_pkg::t_chan_state          o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [sfd_pkg::CH_AW-1:0] i_wr_addr,
    input  wire sfd_pkg::t_chan_state     i_wr_data
);

    sfd_pkg::t_chan_state r_mem [sfd_pkg::NUM_CHANNELS];
    logic [sfd_pkg::NUM_CHANNELS-1:0] r_valid;
    sfd_pkg::t_chan_state r_rd_data;
    logic r_rd_ok;
    logic fwd;

    // A read of the entry being written in the same cycle returns the new value.
    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= fwd ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_ok <= fwd || r_valid[i_rd_addr];
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Entries not yet written since reset read as the all-zero reset state.
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

/* src/sfd_decode.sv */
`default_nettype none

module sfd_decode (
    input  wire sfd_pkg::t_chan_state i_cur,
    input  wire logic [7:0]      i_byte,
    input  wire logic [15:0]     i_max_len,
    output sfd_pkg::t_chan_state o_next,
    output logic                 o_res_valid,
    output sfd_pkg::t_result     o_res
);

    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic [16:0] cnt_inc_wide;
    logic [15:0] err_inc;

    assign len_full     = i_cur.frame_len | {i_byte, 8'h00};
    assign cnt_inc      = i_cur.counted + 16'd1;
    assign cnt_inc_wide = {1'b0, i_cur.counted} + 17'd1;
    assign err_inc      = i_cur.errors + 16'd1;

    always_comb begin
        o_next      = i_cur;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = sfd_pkg::KIND_BYTE;

        unique case (i_cur.phase)
            sfd_pkg::PH_HUNT: begin
                if (i_byte == sfd_pkg::SYNC_A) begin
                    o_next.phase = sfd_pkg::PH_SYNC2;
                end
            end
            sfd_pkg::PH_SYNC2: begin
                o_next.phase = (i_byte == sfd_pkg::SYNC_B) ? sfd_pkg::PH_LEN_LO
                                                           : sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_LEN_LO: begin
                o_next.frame_len  = {8'h00, i_byte};
                o_next.last_sync  = (i_byte == sfd_pkg::SYNC_A);
                o_next.phase      = sfd_pkg::PH_LEN_FILL;
                o_next.resume     = sfd_pkg::PH_LEN_HI;
                o_res_valid       = 1'b1;
                o_res.byte_value  = i_byte;
                o_res.first       = 1'b1;
            end
            sfd_pkg::PH_LEN_FILL: begin
                priority if (i_byte == sfd_pkg::LEN_PAD) begin
                    o_next.phase = i_cur.resume;
                end else if (i_cur.last_sync) begin
                    o_next.phase = (i_byte == sfd_pkg::SYNC_B) ? sfd_pkg::PH_LEN_LO
                                                               : sfd_pkg::PH_HUNT;
                end else begin
                    o_next.phase     = sfd_pkg::PH_HUNT;
                    o_next.last_sync = 1'b0;
                end
            end
            sfd_pkg::PH_LEN_HI: begin
                o_next.last_sync = (i_byte == sfd_pkg::SYNC_A);
                o_next.frame_len = len_full;
                o_res_valid      = 1'b1;
                o_res.byte_value = i_byte;
                if ((len_full != 16'd0) && (len_full <= i_max_len)) begin
                    o_next.counted = '0;
                    o_next.payload = '0;
                    o_next.sum     = '0;
                    o_next.resume  = sfd_pkg::PH_BODY;
                    o_next.phase   = sfd_pkg::PH_LEN_FILL;
                end else begin
                    // A rejected length whose high byte is 0x55 starts a new sync.
                    o_next.phase = (i_byte == sfd_pkg::SYNC_A) ? sfd_pkg::PH_SYNC2
                                                               : sfd_pkg::PH_HUNT;
                end
            end
            sfd_pkg::PH_BODY: begin
                if (i_byte == sfd_pkg::SYNC_A) begin
                    o_next.phase  = sfd_pkg::PH_STUFF;
                    o_next.resume = sfd_pkg::PH_BODY;
                end
                o_res_valid      = 1'b1;
                o_res.byte_value = i_byte;
                o_next.sum       = i_cur.sum + i_byte;
                o_next.payload   = i_cur.payload + 16'd1;
                o_next.counted   = cnt_inc;
                // Reaching the length ends the body even on a 0x55.
                if (cnt_inc >= i_cur.frame_len) begin
                    o_next.phase = sfd_pkg::PH_CHECK;
                end
            end
            sfd_pkg::PH_CHECK: begin
                o_res_valid  = 1'b1;
                o_next.phase = sfd_pkg::PH_HUNT;
                if (i_cur.sum != i_byte) begin
                    o_next.errors     = err_inc;
                    o_res.kind        = sfd_pkg::KIND_CSUM_ERR;
                    o_res.error_total = err_inc;
                end else begin
                    o_res.kind           = sfd_pkg::KIND_ACCEPT;
                    o_res.payload_length = i_cur.payload;
                end
            end
            sfd_pkg::PH_STUFF: begin
                if (i_byte == sfd_pkg::STUFF_BYTE) begin
                    if (cnt_inc_wide >= {1'b0, i_cur.frame_len}) begin
                        o_next.phase = sfd_pkg::PH_CHECK;
                    end else begin
                        o_next.phase = i_cur.resume;
                    end
                    if (i_cur.resume == sfd_pkg::PH_BODY) begin
                        o_next.counted = cnt_inc;
                        o_next.sum     = i_cur.sum + i_byte;
                    end
                end else begin
                    o_next.phase = (i_byte == sfd_pkg::SYNC_B) ? sfd_pkg::PH_LEN_LO
                                                               : sfd_pkg::PH_HUNT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
